// ===== rtl/llrs_pkg.sv =====
// Package for the link loss rate sampler.
// Holds field widths, serial digit constants and the controller state type.
// No dependencies.
`default_nettype none

package llrs_pkg;

  localparam int LINK_W = 32;
  localparam int CNT_W = 64;
  localparam int NUM_W = 32;
  localparam int PERM_W = 10;
  localparam int WIN_W = 32;

  localparam int S_DATA_W = 160;
  localparam int S_USER_W = 2;
  localparam int M_DATA_W = 80;
  localparam int M_USER_W = 2;

  localparam int DIGIT_W = 4;
  localparam int SCAN_STEPS = CNT_W / DIGIT_W;
  localparam int STEP_W = $clog2(SCAN_STEPS);
  localparam int HALF_STEP = WIN_W / DIGIT_W;

  localparam int PROD_W = CNT_W + PERM_W;
  localparam int DIV_STEPS = PERM_W;
  localparam int DSTEP_W = $clog2(DIV_STEPS);

  localparam logic [PERM_W-1:0] PERMILLE_FULL = PERM_W'(1000);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/link_loss_rate_sampler_unit.sv =====
// Link loss rate sampler: one loss report per link sample.
// Uses llrs_pkg and llrs_perm_div.
//
// channel  dir  tdata                                    tuser
// s_*      in   link_number, received_total, lost_total  path_up, counters_valid
// m_*      out  report_number, loss_ppt, window_pk       report_sent, loss_valid
//
// A sample with the path down or counters invalid goes from idle straight to the done state.
// Otherwise the counter deltas are formed 4 bits a cycle in the scan state, then the
// decide state runs, then the permille divider when it is needed. One sample is in
// work at a time; s_tready rises again once the result sits in the output register.
// m_tready low holds the result there. Reset clears the sampler state and the report
// counter.
`default_nettype none

module link_loss_rate_sampler_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // link_number[31:0], received_total[95:32], lost_total[159:96]
  input  wire logic [llrs_pkg::S_DATA_W-1:0]  s_tdata,
  // path_up[0], counters_valid[1]
  input  wire logic [llrs_pkg::S_USER_W-1:0]  s_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // report_number[31:0], loss_ppt[41:32], window_packets[73:42], zero pad
  output logic [llrs_pkg::M_DATA_W-1:0]       m_tdata,
  // report_sent[0], loss_valid[1]
  output logic [llrs_pkg::M_USER_W-1:0]       m_tuser
);
  import llrs_pkg::*;

  state_t              state;
  logic                primed;
  logic [LINK_W-1:0]   last_link;
  logic [CNT_W-1:0]    last_rx;
  logic [CNT_W-1:0]    last_lo;
  logic [NUM_W-1:0]    report_counter;

  logic [LINK_W-1:0]   smp_link;
  logic [CNT_W-1:0]    sh_rx;
  logic [CNT_W-1:0]    sh_lo;
  logic [STEP_W-1:0]   step;
  logic                br_rx;
  logic                br_lo;
  logic                cy;
  logic                rd_zero;
  logic                ld_zero;
  logic                ld_ones;
  logic                hi_nz;

  logic                res_sent;
  logic                res_lv;
  logic [PERM_W-1:0]   res_perm;
  logic [WIN_W-1:0]    res_win;

  logic [DIGIT_W:0]    d_rx;
  logic [DIGIT_W:0]    d_lo;
  logic [DIGIT_W:0]    d_sum;
  logic [CNT_W-1:0]    window;
  logic                accept;
  logic                out_load;
  logic                div_start;
  logic                div_done;
  logic [PERM_W-1:0]   div_q;
  logic [NUM_W-1:0]    cnt_inc;
  logic [NUM_W-1:0]    report_counter_next;

  assign s_tready = (state == ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  assign d_rx = {1'b0, sh_rx[DIGIT_W-1:0]} - {1'b0, last_rx[DIGIT_W-1:0]} - {{DIGIT_W{1'b0}}, br_rx};
  assign d_lo = {1'b0, sh_lo[DIGIT_W-1:0]} - {1'b0, last_lo[DIGIT_W-1:0]} - {{DIGIT_W{1'b0}}, br_lo};
  assign d_sum = {1'b0, d_rx[DIGIT_W-1:0]} + {1'b0, d_lo[DIGIT_W-1:0]} + {{DIGIT_W{1'b0}}, cy};

  assign window = cy ? {CNT_W{1'b1}} : sh_rx;
  assign div_start = (state == ST_DECIDE) && primed && (last_link == smp_link)
                     && !br_rx && !br_lo && !(rd_zero && !ld_zero)
                     && !(cy && ld_ones) && !rd_zero && !ld_zero;

  assign cnt_inc = report_counter + 1'b1;
  assign report_counter_next = (cnt_inc == '0) ? NUM_W'(1) : cnt_inc;

  llrs_perm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .lost     (sh_lo),
    .window   (window),
    .done     (div_done),
    .permille (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      primed <= 1'b0;
      last_link <= '0;
      last_rx <= '0;
      last_lo <= '0;
      report_counter <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (!s_tuser[0] || !s_tuser[1]) begin
              primed <= 1'b0;
              last_link <= '0;
              last_rx <= '0;
              last_lo <= '0;
              state <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          last_rx <= {sh_rx[DIGIT_W-1:0], last_rx[CNT_W-1:DIGIT_W]};
          last_lo <= {sh_lo[DIGIT_W-1:0], last_lo[CNT_W-1:DIGIT_W]};
          if (step == STEP_W'(SCAN_STEPS - 1)) begin
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          if (!primed || last_link != smp_link || br_rx || br_lo) begin
            primed <= 1'b1;
            last_link <= smp_link;
            state <= ST_DONE;
          end else if (div_start) begin
            state <= ST_DIV;
          end else begin
            state <= ST_DONE;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            if (res_sent) begin
              report_counter <= report_counter_next;
            end
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          smp_link <= s_tdata[31:0];
          sh_rx <= s_tdata[95:32];
          sh_lo <= s_tdata[159:96];
          step <= '0;
          br_rx <= 1'b0;
          br_lo <= 1'b0;
          cy <= 1'b0;
          rd_zero <= 1'b1;
          ld_zero <= 1'b1;
          ld_ones <= 1'b1;
          hi_nz <= 1'b0;
          res_sent <= s_tuser[0];
          res_lv <= 1'b0;
          res_perm <= '0;
          res_win <= '0;
        end
      end
      ST_SCAN: begin
        step <= step + 1'b1;
        br_rx <= d_rx[DIGIT_W];
        br_lo <= d_lo[DIGIT_W];
        cy <= d_sum[DIGIT_W];
        sh_rx <= {d_sum[DIGIT_W-1:0], sh_rx[CNT_W-1:DIGIT_W]};
        sh_lo <= {d_lo[DIGIT_W-1:0], sh_lo[CNT_W-1:DIGIT_W]};
        rd_zero <= rd_zero && (d_rx[DIGIT_W-1:0] == '0);
        ld_zero <= ld_zero && (d_lo[DIGIT_W-1:0] == '0);
        ld_ones <= ld_ones && (d_lo[DIGIT_W-1:0] == '1);
        hi_nz <= hi_nz || ((step >= STEP_W'(HALF_STEP)) && (d_sum[DIGIT_W-1:0] != '0));
      end
      ST_DECIDE: begin
        if (primed && last_link == smp_link && !br_rx && !br_lo) begin
          res_lv <= !(rd_zero && ld_zero);
          res_win <= (cy || hi_nz) ? {WIN_W{1'b1}} : sh_rx[WIN_W-1:0];
          if ((rd_zero && !ld_zero) || (cy && ld_ones)) begin
            res_perm <= PERMILLE_FULL;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_perm <= div_q;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          m_tdata <= {{(M_DATA_W - NUM_W - PERM_W - WIN_W){1'b0}}, res_win, res_perm,
                      res_sent ? report_counter_next : {NUM_W{1'b0}}};
          m_tuser <= {res_lv, res_sent};
        end
      end
      default: begin
        step <= '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/llrs_perm_div.sv =====
// Permille divider: floor(lost * 1000 / window) for 0 < lost < window.
// Restoring division, one quotient bit per cycle; uses llrs_pkg.
`default_nettype none

module llrs_perm_div (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire logic [llrs_pkg::CNT_W-1:0]  lost,
  input  wire logic [llrs_pkg::CNT_W-1:0]  window,
  output logic                             done,
  output logic [llrs_pkg::PERM_W-1:0]      permille
);
  import llrs_pkg::*;

  logic                running;
  logic [DSTEP_W-1:0]  step;
  logic [CNT_W-1:0]    rem;
  logic [PERM_W-1:0]   pbits;
  logic [CNT_W-1:0]    dvs;
  logic [PERM_W-1:0]   quo;
  logic [PROD_W-1:0]   prod;
  logic [CNT_W:0]      trial;
  logic [CNT_W:0]      diff;
  logic                ge;

  // lost * 1000 = lost * 1024 - lost * 16 - lost * 8
  assign prod = {lost, 10'b0} - {6'b0, lost, 4'b0} - {7'b0, lost, 3'b0};
  assign trial = {rem, pbits[PERM_W-1]};
  assign ge = trial >= {1'b0, dvs};
  assign diff = trial - {1'b0, dvs};
  assign permille = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == DSTEP_W'(DIV_STEPS - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= prod[PROD_W-1:PERM_W];
      pbits <= prod[PERM_W-1:0];
      dvs <= window;
      quo <= '0;
    end else if (running) begin
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      pbits <= {pbits[PERM_W-2:0], 1'b0};
      quo <= {quo[PERM_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ===== dv/llrs_report_sb_pkg.sv =====
`timescale 1ns / 100ps
// Loss report scoreboard for the link loss rate sampler testbench.
// Predicts one report per accepted sample and checks output beats in order.
// Depends on llrs_pkg.
package llrs_report_sb_pkg;

  import llrs_pkg::*;

  localparam int SU_PATH_UP = 0;
  localparam int SU_CNT_VALID = 1;
  localparam int MU_SENT = 0;
  localparam int MU_LOSS_VALID = 1;
  localparam int REPORT_BITS = NUM_W + PERM_W + WIN_W;

  typedef struct {
    bit              sent;
    bit [NUM_W-1:0]  number;
    bit              loss_valid;
    bit [PERM_W-1:0] permille;
    bit [WIN_W-1:0]  packets;
  } loss_report_t;

  class loss_report_scoreboard;
    bit               primed;
    bit [LINK_W-1:0]  last_link;
    bit [CNT_W-1:0]   last_rx;
    bit [CNT_W-1:0]   last_lost;
    bit [NUM_W-1:0]   report_seq;
    loss_report_t     report_q[$];
    int unsigned      errors;

    function new();
      clear_window();
      report_seq = '0;
      errors = 0;
    endfunction

    function void clear_window();
      primed = 1'b0;
      last_link = '0;
      last_rx = '0;
      last_lost = '0;
    endfunction

    function int unsigned outstanding();
      return report_q.size();
    endfunction

    function void note_sample(bit up, bit cv, bit [LINK_W-1:0] link,
                              bit [CNT_W-1:0] rx, bit [CNT_W-1:0] lost);
      loss_report_t   rep;
      bit [CNT_W-1:0] rx_d;
      bit [CNT_W-1:0] lost_d;
      bit [CNT_W:0]   sum;
      bit [CNT_W-1:0] win;
      bit [127:0]     scaled;
      bit [PERM_W-1:0] perm;
      rep = '{default: '0};
      win = '0;
      perm = '0;
      if (!up) begin
        clear_window();
        report_q.push_back(rep);
        return;
      end
      if (!cv) begin
        clear_window();
      end else if (!primed || link != last_link || rx < last_rx || lost < last_lost) begin
        primed = 1'b1;
        last_link = link;
        last_rx = rx;
        last_lost = lost;
      end else begin
        rx_d = rx - last_rx;
        lost_d = lost - last_lost;
        sum = {1'b0, rx_d} + {1'b0, lost_d};
        win = sum[CNT_W] ? '1 : sum[CNT_W-1:0];
        if (win != 0 && lost_d != 0) begin
          if (lost_d >= win) begin
            perm = PERMILLE_FULL;
          end else begin
            scaled = (128'(lost_d) * 128'(PERMILLE_FULL)) / 128'(win);
            perm = scaled[PERM_W-1:0];
          end
        end
        last_rx = rx;
        last_lost = lost;
      end
      // skip zero on wrap
      report_seq = report_seq + 1'b1;
      if (report_seq == 0) report_seq = 1;
      rep.sent = 1'b1;
      rep.number = report_seq;
      rep.loss_valid = (win != 0);
      rep.permille = perm;
      rep.packets = (win > 64'(32'hFFFF_FFFF)) ? '1 : win[WIN_W-1:0];
      report_q.push_back(rep);
    endfunction

    function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (act_v !== exp_v) begin
        $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_report(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] user);
      loss_report_t rep;
      if (report_q.size() == 0) begin
        $error("report beat with no sample waiting");
        errors++;
        return;
      end
      rep = report_q.pop_front();
      compare_field("report_sent", 64'(rep.sent), 64'(user[MU_SENT]));
      compare_field("report_number", 64'(rep.number), 64'(data[NUM_W-1:0]));
      compare_field("loss_valid", 64'(rep.loss_valid), 64'(user[MU_LOSS_VALID]));
      compare_field("loss_ppt", 64'(rep.permille), 64'(data[NUM_W +: PERM_W]));
      compare_field("window_packets", 64'(rep.packets), 64'(data[NUM_W+PERM_W +: WIN_W]));
      compare_field("tdata_pad", 64'd0, 64'(data[M_DATA_W-1:REPORT_BITS]));
    endfunction
  endclass

endpackage

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench top for link_loss_rate_sampler_unit.
// Streams link samples in and checks loss reports through llrs_report_sb_pkg.
// Depends on llrs_pkg, llrs_report_sb_pkg and the RTL.
module tb_top;

  import llrs_pkg::*;
  import llrs_report_sb_pkg::*;

  localparam int CLK_HALF = 10;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 60;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata = '0;
  logic [S_USER_W-1:0] s_tuser = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [M_DATA_W-1:0] m_tdata;
  logic [M_USER_W-1:0] m_tuser;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_reqs = 0;
  loss_report_scoreboard sb = new();

  always #CLK_HALF clk = ~clk;

  link_loss_rate_sampler_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin : report_sink
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_report(m_tdata, m_tuser);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_sample(bit up, bit cv, bit [LINK_W-1:0] link,
                             bit [CNT_W-1:0] rx, bit [CNT_W-1:0] lost);
    bit [S_USER_W-1:0] user;
    user = '0;
    user[SU_PATH_UP] = up;
    user[SU_CNT_VALID] = cv;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {lost, rx, link};
    s_tuser <= user;
    do @(posedge clk); while (!s_tready);
    sb.note_sample(up, cv, link, rx, lost);
  endtask

  function automatic bit [CNT_W-1:0] rand_u64();
    return {$urandom, $urandom};
  endfunction

  function automatic bit [CNT_W-1:0] rand_base();
    case ($urandom_range(2))
      0: return rand_u64();
      1: return 64'($urandom_range(1 << 20));
      default: return '1 - 64'($urandom_range(4096));
    endcase
  endfunction

  function automatic bit [CNT_W-1:0] rand_rx_step();
    case ($urandom_range(9))
      0: return '0;
      1, 2, 3, 4, 5: return 64'($urandom_range(2000));
      6, 7: return 64'($urandom);
      8: return {24'd0, 8'($urandom_range(255)), 32'($urandom)};
      default: return rand_u64();
    endcase
  endfunction

  function automatic bit [CNT_W-1:0] rand_lost_step();
    case ($urandom_range(5))
      0, 1: return '0;
      2, 3: return 64'($urandom_range(100));
      default: return rand_rx_step();
    endcase
  endfunction

  task automatic run_directed();
    send_sample(1'b0, 1'b1, '1, '1, '1);               // path down
    send_sample(1'b1, 1'b0, '1, '1, '1);               // counters invalid
    send_sample(1'b1, 1'b1, '0, '0, '0);               // first sample primes
    send_sample(1'b1, 1'b1, '0, '0, '0);               // empty window
    send_sample(1'b1, 1'b1, '0, 64'd1000, 64'd10);
    send_sample(1'b1, 1'b1, '0, 64'd1000, 64'd50);     // every packet lost
    send_sample(1'b1, 1'b1, '0, 64'd1000 + (64'd1 << 40), 64'd50 + (64'd1 << 33));
    // loss product wider than 64 bits
    send_sample(1'b1, 1'b1, '0, 64'd1000 + (64'd1 << 40) + (64'd1 << 63),
                64'd50 + (64'd1 << 33) + (64'd1 << 62));
    send_sample(1'b1, 1'b1, '0, '0, '0);               // counters go backwards
    send_sample(1'b1, 1'b1, '0, '1, 64'h8000_0000_0000_0000);  // window saturates
    send_sample(1'b1, 1'b1, '1, '0, '0);               // link change
    send_sample(1'b1, 1'b1, '1, '1, '1);
    send_sample(1'b1, 1'b1, '1, 64'd100, 64'd100);     // received goes backwards
    send_sample(1'b1, 1'b1, '1, 64'd300, 64'd50);      // lost goes backwards
    send_sample(1'b1, 1'b1, '1, 64'd5000, 64'd50);
    send_sample(1'b1, 1'b1, '1, 64'd5000, 64'd51);
    send_sample(1'b0, 1'b0, '1, 64'd6000, 64'd60);
    send_sample(1'b1, 1'b1, '1, 64'd6000, 64'd60);
    send_sample(1'b1, 1'b1, '1, 64'd7000, 64'd70);
    send_sample(1'b1, 1'b0, '1, 64'd8000, 64'd80);
    send_sample(1'b1, 1'b1, '1, 64'd8000, 64'd80);
    send_sample(1'b1, 1'b1, '1, 64'd8001, 64'd1080);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned     sent;
    int unsigned     pick;
    int unsigned     len;
    bit [LINK_W-1:0] link;
    bit [CNT_W-1:0]  rx;
    bit [CNT_W-1:0]  lost;
    sent = 0;
    link = $urandom;
    rx = rand_base();
    lost = rand_base();
    while (sent < count) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(2) != 0) begin
          link = $urandom;
          rx = rand_base();
          lost = rand_base();
        end
        len = $urandom_range(3, 12);
        repeat (len) begin
          pick = $urandom_range(99);
          if (pick < 3) begin
            send_sample(1'b0, 1'($urandom_range(1)), link, rx, lost);
          end else if (pick < 6) begin
            send_sample(1'b1, 1'b0, link, rx, lost);
          end else if (pick < 9) begin
            rx = rx - 64'($urandom_range(1, 100));
            send_sample(1'b1, 1'b1, link, rx, lost);
          end else begin
            send_sample(1'b1, 1'b1, link, rx, lost);
          end
          sent++;
          rx = rx + rand_rx_step();
          lost = lost + rand_lost_step();
        end
      end else begin
        send_sample(1'($urandom_range(1)), 1'($urandom_range(1)), $urandom,
                    rand_u64(), rand_u64());
        sent++;
      end
    end
  endtask

  task automatic drain_reports();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin : stimulus
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random(440);

    // stall the output long enough to back up the input
    hold_reqs <= hold_reqs + 1;
    run_random(30);
    drain_reports();

    send_idle_pct = 65;
    run_random(440);
    send_idle_pct = 0;
    recv_stall_pct = 65;
    run_random(440);
    send_idle_pct = 21;
    recv_stall_pct = 21;
    run_random(440);

    drain_reports();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
